/* sv/bsm_pkg.sv */
package bsm_pkg;

	// byte lanes of the store; one bank per lane
	localparam int LANES   = 8;
	localparam int LANE_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int SIZE_W  = 4;
	localparam int VALUE_W = LANES * BYTE_W;

	// operation codes
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_DUP   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

/* sv/bsm_ifs.sv */
// request channel: one stack operation per item
interface bsm_req_if import bsm_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [SIZE_W-1:0]  size;
	logic [VALUE_W-1:0] push_value;

	modport source (output valid, output op, output size, output push_value, input ready);
	modport sink   (input valid, input op, input size, input push_value, output ready);
endinterface

// response channel: one result per operation
interface bsm_rsp_if import bsm_pkg::*; #(
	parameter int FILL_W = 11
);
	logic               valid;
	logic               ready;
	logic               status;
	logic [VALUE_W-1:0] pop_value;
	logic [FILL_W-1:0]  fill;

	modport source (output valid, output status, output pop_value, output fill, input ready);
	modport sink   (input valid, input status, input pop_value, input fill, output ready);
endinterface

/* sv/bsm_bank.sv */
// one byte bank: single write port, single registered read port
module bsm_bank import bsm_pkg::*; #(
	parameter int ROWS = 128,
	localparam int ROW_W = $clog2(ROWS)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ROW_W-1:0] waddr,
	input  byte_t            wdata,
	input  logic [ROW_W-1:0] raddr,
	output byte_t            rdata
);

	byte_t mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* sv/byte_stack_multiwidth.sv */
// Byte-addressed operand stack. Each request item pushes, pops or duplicates
// 1 to 8 bytes, or clears the stack, and gets exactly one response item with
// status, popped value and the fill level afterwards. The store is split into
// eight byte banks, so any run of up to eight consecutive bytes is one access
// per bank. An item passes through an accept step and a response step: in
// the accept step the range checks run, push bytes are written and the banks
// are read at the top of stack; in the response step (busy_s1) the read bytes
// are rotated into order, duplicated bytes are written back and the response
// register is loaded. No new item is taken while one is in the response step,
// nor while a response waits unread. The store needs no clearing after reset.
module byte_stack_multiwidth import bsm_pkg::*; #(
	parameter int STACK_BYTES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	bsm_req_if.sink    req,
	bsm_rsp_if.source  rsp
);

	localparam int FILL_W = $clog2(STACK_BYTES + 1);
	localparam int ROWS   = (STACK_BYTES + LANES - 1) / LANES;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int HI_W   = FILL_W - LANE_W;

	logic [FILL_W-1:0]  fill_q;
	logic               busy_s1;
	logic               pop_s1;
	logic               dup_s1;
	logic               status_s1;
	logic [SIZE_W-1:0]  size_s1;
	logic [LANE_W-1:0]  rofs_s1;
	logic [FILL_W-1:0]  wbase_s1;

	logic               rsp_valid_q;
	logic               rsp_status_q;
	logic [VALUE_W-1:0] rsp_pop_q;

	logic               acc;
	op_t                op_w;
	logic [FILL_W-1:0]  size_ext;
	logic [FILL_W:0]    sum_w;
	logic               size_ok;
	logic               room;
	logic               enough;
	logic               ok_w;
	logic [FILL_W-1:0]  rbase_w;
	logic [FILL_W-1:0]  fill_nxt;

	byte_t              rdata [LANES];
	byte_t              lane_w [LANES];
	logic [VALUE_W-1:0] pop_w;

	// handshake: one item in flight, response register must be free
	assign req.ready = !busy_s1 && (!rsp_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	// range checks against the current fill level
	assign op_w     = op_t'(req.op);
	assign size_ext = {{(FILL_W - SIZE_W){1'b0}}, req.size};
	assign sum_w    = {1'b0, fill_q} + {1'b0, size_ext};
	assign size_ok  = (req.size != '0) && (req.size <= SIZE_W'(LANES));
	assign room     = sum_w <= (FILL_W + 1)'(STACK_BYTES);
	assign enough   = size_ext <= fill_q;
	assign rbase_w  = fill_q - size_ext;

	always_comb begin
		ok_w     = 1'b0;
		fill_nxt = fill_q;
		unique case (op_w)
			OP_PUSH: begin
				ok_w = size_ok && room;
				if (ok_w) fill_nxt = sum_w[FILL_W-1:0];
			end
			OP_POP: begin
				ok_w = size_ok && enough;
				if (ok_w) fill_nxt = rbase_w;
			end
			OP_DUP: begin
				ok_w = size_ok && enough && room;
				if (ok_w) fill_nxt = sum_w[FILL_W-1:0];
			end
			OP_CLEAR: begin
				ok_w     = 1'b1;
				fill_nxt = '0;
			end
			default: begin
				ok_w     = 1'b0;
				fill_nxt = fill_q;
			end
		endcase
	end

	// fill level and second-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= acc;
			if (acc) fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pop_s1    <= ok_w && (op_w == OP_POP);
			dup_s1    <= ok_w && (op_w == OP_DUP);
			status_s1 <= !ok_w;
			size_s1   <= req.size;
			rofs_s1   <= rbase_w[LANE_W-1:0];
			wbase_s1  <= fill_q;
		end
	end

	// rotate bank outputs into byte order of the popped run
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_w[i] = rdata[LANE_W'(i) + rofs_s1];
		end
	end

	always_comb begin
		pop_w = '0;
		for (int i = 0; i < LANES; i++) begin
			if (pop_s1 && (SIZE_W'(i) < size_s1)) pop_w[BYTE_W*i +: BYTE_W] = lane_w[i];
		end
	end

	// byte banks; write port shared by push (accept step) and duplicate (response step)
	for (genvar b = 0; b < LANES; b++) begin : g_bank
		logic [LANE_W-1:0] pj;
		logic [LANE_W-1:0] dj;
		logic [HI_W-1:0]   prow;
		logic [HI_W-1:0]   drow;
		logic [HI_W-1:0]   rrow;
		logic              we;
		logic [ROW_W-1:0]  waddr;
		byte_t             wdata;

		always_comb begin
			pj   = LANE_W'(b) - fill_q[LANE_W-1:0];
			dj   = LANE_W'(b) - wbase_s1[LANE_W-1:0];
			prow = fill_q[FILL_W-1:LANE_W]
			     + HI_W'(LANE_W'(b) < fill_q[LANE_W-1:0]);
			drow = wbase_s1[FILL_W-1:LANE_W]
			     + HI_W'(LANE_W'(b) < wbase_s1[LANE_W-1:0]);
			rrow = rbase_w[FILL_W-1:LANE_W]
			     + HI_W'(LANE_W'(b) < rbase_w[LANE_W-1:0]);
			if (busy_s1) begin
				we    = dup_s1 && ({1'b0, dj} < size_s1);
				waddr = drow[ROW_W-1:0];
				wdata = lane_w[dj];
			end else begin
				we    = acc && ok_w && (op_w == OP_PUSH) && ({1'b0, pj} < req.size);
				waddr = prow[ROW_W-1:0];
				wdata = req.push_value[BYTE_W*pj +: BYTE_W];
			end
		end

		bsm_bank #(.ROWS(ROWS)) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.raddr (rrow[ROW_W-1:0]),
			.rdata (rdata[b])
		);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (busy_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			rsp_status_q <= status_s1;
			rsp_pop_q    <= pop_w;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.pop_value = rsp_pop_q;
	assign rsp.fill      = fill_q;

endmodule

/* sv/bsm_chk.sv */
// port-level checks for the operand stack
module bsm_chk import bsm_pkg::*; #(
	parameter int STACK_BYTES = 1024,
	parameter int FILL_W      = 11
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_status,
	input logic [VALUE_W-1:0] rsp_pop_value,
	input logic [FILL_W-1:0]  rsp_fill
);

	// every accepted item is followed by a valid response
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> ##2 rsp_valid)
		else $error("no response after accepted item");

	// one item at a time: no accept on consecutive edges
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !(req_valid && req_ready))
		else $error("item accepted while previous one in flight");

	// a failed item returns no data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status) |-> (rsp_pop_value == '0))
		else $error("error response carries data");

	// fill level never beyond the store
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_fill <= FILL_W'(STACK_BYTES)))
		else $error("fill level beyond store size");

	// a waiting response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pop_value)
			&& $stable(rsp_status) && $stable(rsp_fill)))
		else $error("response changed while stalled");

endmodule

bind byte_stack_multiwidth bsm_chk #(
	.STACK_BYTES (STACK_BYTES),
	.FILL_W      (FILL_W)
) u_bsm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_pop_value (rsp.pop_value),
	.rsp_fill      (rsp.fill)
);

/* tb/sv/byte_stack_multiwidth_test.sv */
`timescale 1ns / 1ps

module byte_stack_multiwidth_test import bsm_pkg::*;;

	localparam int STACK_BYTES  = 1024;
	localparam int FILL_W       = 11;
	localparam int TOTAL_OPS    = 1100;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int QUIET_LO     = 1000;
	localparam int QUIET_HI     = 1800;
	localparam int DRAIN_CYCLES = 20;

	// random modes of the stimulus
	localparam int MODE_GROW  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct {
		op_t                op;
		logic [SIZE_W-1:0]  size;
		logic [VALUE_W-1:0] value;
	} stack_req_t;

	typedef struct {
		logic               status;
		logic [VALUE_W-1:0] pop_value;
		logic [FILL_W-1:0]  fill;
	} stack_result_t;

	logic clk;
	logic arst_n;

	bsm_req_if req_ch ();
	bsm_rsp_if #(.FILL_W(FILL_W)) rsp_ch ();

	byte_stack_multiwidth #(.STACK_BYTES(STACK_BYTES)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stack_req_t    pending_ops[$];
	stack_result_t due_results[$];

	// shadow copy of the stack contents and level
	byte_t shadow_bytes [STACK_BYTES];
	int    shadow_fill;

	int   cycles;
	int   errors;
	int   ops_taken;
	int   ops_queued;
	logic req_taken;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// work out the response to one request item and update the shadow stack
	function automatic stack_result_t apply_stack_op(stack_req_t r);
		stack_result_t res;
		int n;
		int base;
		res.status    = 1'b0;
		res.pop_value = '0;
		n = r.size;
		if (r.op == OP_CLEAR) begin
			shadow_fill = 0;
		end else if (n < 1 || n > LANES) begin
			res.status = 1'b1;
		end else begin
			case (r.op)
				OP_PUSH: begin
					if (shadow_fill + n > STACK_BYTES) begin
						res.status = 1'b1;
					end else begin
						for (int i = 0; i < n; i++)
							shadow_bytes[shadow_fill + i] = r.value[BYTE_W*i +: BYTE_W];
						shadow_fill += n;
					end
				end
				OP_POP: begin
					if (n > shadow_fill) begin
						res.status = 1'b1;
					end else begin
						base = shadow_fill - n;
						for (int i = 0; i < n; i++)
							res.pop_value[BYTE_W*i +: BYTE_W] = shadow_bytes[base + i];
						shadow_fill = base;
					end
				end
				default: begin
					// duplicate: needs n bytes present and n bytes free
					if (n > shadow_fill || shadow_fill + n > STACK_BYTES) begin
						res.status = 1'b1;
					end else begin
						base = shadow_fill - n;
						for (int i = 0; i < n; i++)
							shadow_bytes[shadow_fill + i] = shadow_bytes[base + i];
						shadow_fill += n;
					end
				end
			endcase
		end
		res.fill = shadow_fill[FILL_W-1:0];
		return res;
	endfunction

	// random gaps on both sides, none inside the quiet window
	function automatic bit take_break();
		return (cycles < QUIET_LO || cycles >= QUIET_HI) && $urandom_range(0, 99) < 20;
	endfunction

	// mostly legal sizes, now and then one out of range
	function automatic logic [SIZE_W-1:0] pick_size();
		int v;
		if ($urandom_range(0, 99) < 95)
			return SIZE_W'($urandom_range(1, LANES));
		v = $urandom_range(0, 7);
		return (v == 0) ? '0 : SIZE_W'(v + 8);
	endfunction

	task automatic add_op(op_t op, int size, logic [VALUE_W-1:0] value);
		stack_req_t r;
		r.op    = op;
		r.size  = SIZE_W'(size);
		r.value = value;
		pending_ops.push_back(r);
	endtask

	// request driver: new item at the falling edge once the last one is taken
	always @(negedge clk) begin
		stack_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_ops.size() != 0 && !take_break()) begin
				nxt = pending_ops.pop_front();
				req_ch.op         <= nxt.op;
				req_ch.size       <= nxt.size;
				req_ch.push_value <= nxt.value;
				req_ch.valid      <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		rsp_ch.ready <= arst_n && !take_break();
	end

	// monitor: predict on each accepted request, check each accepted response
	always @(posedge clk) begin
		stack_req_t    got_req;
		stack_result_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				got_req.op    = op_t'(req_ch.op);
				got_req.size  = req_ch.size;
				got_req.value = req_ch.push_value;
				due_results.push_back(apply_stack_op(got_req));
				ops_taken++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: response with none expected: status %0b pop %h fill %0d",
						$time, rsp_ch.status, rsp_ch.pop_value, rsp_ch.fill);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (rsp_ch.status !== want.status) begin
						$display("%0t: status expected %0b actual %0b",
							$time, want.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.pop_value !== want.pop_value) begin
						$display("%0t: pop_value expected %h actual %h",
							$time, want.pop_value, rsp_ch.pop_value);
						errors++;
					end
					if (rsp_ch.fill !== want.fill) begin
						$display("%0t: fill expected %0d actual %0d",
							$time, want.fill, rsp_ch.fill);
						errors++;
					end
				end
			end
		end
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, due_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int mode;
		int len;
		int roll;
		op_t op;

		cycles      = 0;
		errors      = 0;
		ops_taken   = 0;
		shadow_fill = 0;
		req_taken   = 1'b0;
		arst_n      = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_PUSH;
		req_ch.size       = '0;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;

		// directed: empty-stack errors, size limits, extreme values, clear
		add_op(OP_POP, 1, '0);
		add_op(OP_DUP, 1, '0);
		add_op(OP_PUSH, 0, '1);
		add_op(OP_PUSH, 15, '1);
		add_op(OP_PUSH, 1, '1);
		add_op(OP_PUSH, 8, '1);
		add_op(OP_PUSH, 8, '0);
		add_op(OP_PUSH, 8, 64'h0123_4567_89ab_cdef);
		add_op(OP_PUSH, 3, 64'h8000_0000_00a5_5a01);
		add_op(OP_DUP, 8, '0);
		add_op(OP_DUP, 1, '1);
		add_op(OP_DUP, 0, '0);
		add_op(OP_DUP, 12, '0);
		add_op(OP_POP, 8, '0);
		add_op(OP_POP, 1, '0);
		add_op(OP_POP, 9, '0);
		add_op(OP_POP, 0, '0);
		add_op(OP_POP, 5, '0);
		add_op(OP_CLEAR, 0, '1);
		add_op(OP_POP, 1, '0);
		add_op(OP_PUSH, 2, 64'hffff_ffff_ffff_beef);
		add_op(OP_DUP, 4, '0);
		add_op(OP_POP, 3, '0);
		add_op(OP_CLEAR, 15, '0);
		add_op(OP_PUSH, 8, 64'h8000_0000_0000_0000);

		// random phases: mostly growing the stack, mostly draining it, or mixed
		while (pending_ops.size() < TOTAL_OPS) begin
			mode = $urandom_range(MODE_GROW, MODE_MIXED);
			len  = $urandom_range(150, 400);
			for (int k = 0; k < len && pending_ops.size() < TOTAL_OPS; k++) begin
				roll = $urandom_range(0, 999);
				case (mode)
					MODE_GROW: begin
						op = (roll < 650) ? OP_PUSH : (roll < 900) ? OP_DUP :
							(roll < 998) ? OP_POP : OP_CLEAR;
					end
					MODE_DRAIN: begin
						op = (roll < 700) ? OP_POP : (roll < 850) ? OP_PUSH :
							(roll < 960) ? OP_DUP : OP_CLEAR;
					end
					default: begin
						op = (roll < 350) ? OP_PUSH : (roll < 700) ? OP_POP :
							(roll < 970) ? OP_DUP : OP_CLEAR;
					end
				endcase
				add_op(op, (op == OP_CLEAR) ? $urandom_range(0, 15) : pick_size(),
					{$urandom, $urandom});
			end
		end
		ops_queued = pending_ops.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every item to go in and every response to come out
		while (ops_taken < ops_queued) @(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* byte_stack_multiwidth.f */
sv/bsm_pkg.sv
sv/bsm_ifs.sv
sv/bsm_bank.sv
sv/byte_stack_multiwidth.sv
sv/bsm_chk.sv
tb/sv/byte_stack_multiwidth_test.sv
